[rtl/core/pbtd_pkg.sv]
// Shared constants, register indexes and types for the PPG beat trough detector.
package pbtd_pkg;

  localparam int unsigned SAMPLE_BITS = 18;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned ALPHA_BITS  = 16;
  localparam int unsigned WL_BITS     = 10;
  localparam int unsigned THR_BITS    = 19;
  localparam int unsigned REF_BITS    = 8;
  localparam int unsigned AC_BITS     = 19;

  // DC level is unsigned QSAMPLE.FRAC; AC values carry two guard bits for the sign.
  localparam int unsigned DC_BITS     = SAMPLE_BITS + FRAC_BITS;
  localparam int unsigned ACF_BITS    = DC_BITS + 2;
  localparam int unsigned ACI_BITS    = ACF_BITS - FRAC_BITS;
  localparam int unsigned PROD_BITS   = DC_BITS + ALPHA_BITS;

  localparam int unsigned IN_TDATA_W  = 24;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 19;

  localparam logic [ALPHA_BITS-1:0]      ALPHA_FAST_RST = ALPHA_BITS'(3277);
  localparam logic [ALPHA_BITS-1:0]      ALPHA_SLOW_RST = ALPHA_BITS'(66);
  localparam logic [WL_BITS-1:0]         WARMUP_LEN_RST = WL_BITS'(200);
  localparam logic signed [THR_BITS-1:0] TROUGH_THR_RST = -THR_BITS'(500);
  localparam logic [REF_BITS-1:0]        REFRACT_RST    = REF_BITS'(40);

  localparam logic signed [ACI_BITS-1:0] AC_MAX = ACI_BITS'((2 ** (AC_BITS - 1)) - 1);
  localparam logic signed [ACI_BITS-1:0] AC_MIN = -AC_MAX;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_FAST  = 3'd0,
    CFG_ALPHA_SLOW  = 3'd1,
    CFG_WARMUP_LEN  = 3'd2,
    CFG_TROUGH_THR  = 3'd3,
    CFG_REFRACT_LEN = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ALPHA_BITS-1:0]      alpha_fast;
    logic [ALPHA_BITS-1:0]      alpha_slow;
    logic [WL_BITS-1:0]         warmup_len;
    logic signed [THR_BITS-1:0] trough_threshold;
    logic [REF_BITS-1:0]        refractory_len;
  } cfg_t;

  // Level tracker result handed to the beat test.
  typedef struct packed {
    logic signed [ACF_BITS-1:0] ac;
    logic                       warm;
  } dc_res_t;

endpackage

[rtl/core/ppg_beat_trough_detector.sv]
// Top level: input register, level tracker, beat test and result register.
// An accepted sample passes the input register, then the result register.
// Throughput: one sample per cycle while m_axis_tready keeps the result moving;
// the IIR multiply-accumulate and the beat test are combinational between the two.
// Reset (rst_ni, asynchronous, active low) clears the DC level, warmup count,
// previous AC and refractory count, and loads the register defaults.
module ppg_beat_trough_detector (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // [17:0] ir_sample, [23:18] zero
  input  logic [pbtd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [0] beat, [19:1] ac_level, [20] warmed_up, [23:21] zero
  output logic [pbtd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pbtd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pbtd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import pbtd_pkg::*;

  cfg_t                     cfg;
  dc_res_t                  dc_res;
  logic                     in_vld_q;
  logic [SAMPLE_BITS-1:0]   sample_q;
  logic                     out_vld_q;
  logic                     beat;
  logic signed [AC_BITS-1:0] ac_level;
  logic                     beat_q;
  logic [AC_BITS-1:0]       ac_level_q;
  logic                     warm_q;
  logic                     adv;
  logic                     in_take;

  // Advance the held sample when the result register is free or being drained
  assign adv           = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;
  assign in_take       = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_vld_q <= s_axis_tvalid;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= s_axis_tdata[SAMPLE_BITS-1:0];
    end
    if (adv) begin
      beat_q     <= beat;
      ac_level_q <= ac_level;
      warm_q     <= dc_res.warm;
    end
  end

  pbtd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  pbtd_dc_track u_dc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .adv_i    (adv),
    .sample_i (sample_q),
    .cfg_i    (cfg),
    .res_o    (dc_res)
  );

  pbtd_beat_detect u_beat (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .res_i      (dc_res),
    .cfg_i      (cfg),
    .beat_o     (beat),
    .ac_level_o (ac_level)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OUT_TDATA_W-AC_BITS-2)'(0), warm_q, ac_level_q, beat_q};

endmodule

[rtl/core/pbtd_cfg_regs.sv]
// Configuration register bank written through the index/data request channel.
module pbtd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pbtd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pbtd_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output pbtd_pkg::cfg_t                 cfg_o
);
  import pbtd_pkg::*;

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_ALPHA_FAST:  cfg_d.alpha_fast       = cfg_data_i[ALPHA_BITS-1:0];
        CFG_ALPHA_SLOW:  cfg_d.alpha_slow       = cfg_data_i[ALPHA_BITS-1:0];
        CFG_WARMUP_LEN:  cfg_d.warmup_len       = cfg_data_i[WL_BITS-1:0];
        CFG_TROUGH_THR:  cfg_d.trough_threshold = $signed(cfg_data_i[THR_BITS-1:0]);
        CFG_REFRACT_LEN: cfg_d.refractory_len   = cfg_data_i[REF_BITS-1:0];
        default: ; // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alpha_fast       <= ALPHA_FAST_RST;
      cfg_q.alpha_slow       <= ALPHA_SLOW_RST;
      cfg_q.warmup_len       <= WARMUP_LEN_RST;
      cfg_q.trough_threshold <= TROUGH_THR_RST;
      cfg_q.refractory_len   <= REFRACT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[rtl/core/pbtd_dc_track.sv]
// DC level IIR tracker with warmup counter; produces the full-precision AC value.
module pbtd_dc_track (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             adv_i,
  input  logic [pbtd_pkg::SAMPLE_BITS-1:0] sample_i,
  input  pbtd_pkg::cfg_t                   cfg_i,
  output pbtd_pkg::dc_res_t                res_o
);
  import pbtd_pkg::*;

  logic [DC_BITS-1:0]   dc_q, dc_d;
  logic [WL_BITS-1:0]   cnt_q, cnt_d;
  logic [WL_BITS-1:0]   len;
  logic [WL_BITS:0]     cnt_inc;
  logic                 first;
  logic                 warm;
  logic [DC_BITS-1:0]   x;
  logic                 above;
  logic [DC_BITS-1:0]   mag;
  logic [ALPHA_BITS-1:0] alpha;
  logic [PROD_BITS-1:0] prod;
  logic [PROD_BITS:0]   prod_rnd;

  assign len     = (cfg_i.warmup_len == '0) ? WL_BITS'(1) : cfg_i.warmup_len;
  assign first   = (cnt_q == '0);
  assign cnt_inc = {1'b0, cnt_q} + (WL_BITS+1)'(1);
  // Clamp to the length so that a lowered length takes effect at once
  assign cnt_d   = (cnt_inc > {1'b0, len}) ? len : cnt_inc[WL_BITS-1:0];
  assign warm    = (cnt_d >= len);

  assign x        = {sample_i, {FRAC_BITS{1'b0}}};
  assign above    = (x >= dc_q);
  assign mag      = above ? (x - dc_q) : (dc_q - x);
  assign alpha    = warm ? cfg_i.alpha_slow : cfg_i.alpha_fast;
  assign prod     = PROD_BITS'(mag) * PROD_BITS'(alpha);
  // Round the downward step up so the level moves by floor of the signed step
  assign prod_rnd = {1'b0, prod} + (PROD_BITS+1)'((2 ** ALPHA_BITS) - 1);

  always_comb begin
    if (first) begin
      dc_d = x;
    end else if (above) begin
      dc_d = dc_q + prod[PROD_BITS-1:ALPHA_BITS];
    end else begin
      dc_d = dc_q - prod_rnd[PROD_BITS-1:ALPHA_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dc_q  <= '0;
      cnt_q <= '0;
    end else if (adv_i) begin
      dc_q  <= dc_d;
      cnt_q <= cnt_d;
    end
  end

  assign res_o.ac   = $signed({2'b00, x}) - $signed({2'b00, dc_d});
  assign res_o.warm = warm;

endmodule

[rtl/core/pbtd_beat_detect.sv]
// Trough recovery test with refractory lockout and integer AC output.
module pbtd_beat_detect (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                adv_i,
  input  pbtd_pkg::dc_res_t                   res_i,
  input  pbtd_pkg::cfg_t                      cfg_i,
  output logic                                beat_o,
  output logic signed [pbtd_pkg::AC_BITS-1:0] ac_level_o
);
  import pbtd_pkg::*;

  logic signed [ACF_BITS-1:0] prev_ac_q;
  logic [REF_BITS-1:0]        refr_q, refr_d;
  logic signed [ACF_BITS-1:0] thr;
  logic signed [ACI_BITS-1:0] ac_int;
  logic                       hit;

  assign thr = $signed({{(ACF_BITS-THR_BITS-FRAC_BITS){cfg_i.trough_threshold[THR_BITS-1]}},
                        cfg_i.trough_threshold, {FRAC_BITS{1'b0}}});
  assign hit = (prev_ac_q < thr) && (res_i.ac > prev_ac_q);

  always_comb begin
    refr_d = refr_q;
    beat_o = 1'b0;
    if (res_i.warm) begin
      if (refr_q != '0) begin
        refr_d = refr_q - REF_BITS'(1);
      end else if (hit) begin
        beat_o = 1'b1;
        refr_d = cfg_i.refractory_len;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_ac_q <= '0;
      refr_q    <= '0;
    end else if (adv_i) begin
      prev_ac_q <= res_i.ac;
      refr_q    <= refr_d;
    end
  end

  // Arithmetic shift floors toward minus infinity
  assign ac_int = res_i.ac[ACF_BITS-1:FRAC_BITS];

  always_comb begin
    if (ac_int > AC_MAX) begin
      ac_level_o = AC_MAX[AC_BITS-1:0];
    end else if (ac_int < AC_MIN) begin
      ac_level_o = AC_MIN[AC_BITS-1:0];
    end else begin
      ac_level_o = ac_int[AC_BITS-1:0];
    end
  end

endmodule

[bench/ppg_beat_trough_detector_test.sv]
// Self-checking bench for the PPG beat trough detector: directed table, then PPG-like runs.
module ppg_beat_trough_detector_test;
  import pbtd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned GAP_PCT     = 14;
  localparam int unsigned SETTLE      = 4;
  localparam int unsigned SAMPLE_MAX  = (1 << SAMPLE_BITS) - 1;

  typedef struct packed {
    logic                      beat;
    logic signed [AC_BITS-1:0] ac;
    logic                      warm;
  } trough_res_t;

  typedef enum logic [1:0] {
    ROW_TYPED,
    ROW_PREDICT,
    ROW_WRITE
  } row_kind_e;

  typedef struct packed {
    row_kind_e              kind;
    cfg_idx_e               idx;
    logic [CFG_DATA_W-1:0]  value;
    trough_res_t            typed;
  } stim_row_t;

  localparam int unsigned DIR_ROWS = 25;

  // value is the sample on sample rows and the register data on write rows
  stim_row_t dir_rows [DIR_ROWS] = '{
    // first sample loads the level directly, so AC is zero
    '{ROW_TYPED,   CFG_ALPHA_FAST,  19'd262143, '{1'b0, 19'sd0, 1'b0}},
    '{ROW_TYPED,   CFG_ALPHA_FAST,  19'd262143, '{1'b0, 19'sd0, 1'b0}},
    '{ROW_PREDICT, CFG_ALPHA_FAST,  19'd0,      '0},
    '{ROW_PREDICT, CFG_ALPHA_FAST,  19'd0,      '0},
    '{ROW_PREDICT, CFG_ALPHA_FAST,  19'd131072, '0},
    // zero warmup length acts as one; lowered length clamps the count
    '{ROW_WRITE,   CFG_WARMUP_LEN,  19'd0,      '0},
    // zero coefficient freezes the level
    '{ROW_WRITE,   CFG_ALPHA_SLOW,  19'd0,      '0},
    // positive threshold
    '{ROW_WRITE,   CFG_TROUGH_THR,  19'd1000,   '0},
    // no lockout after a beat
    '{ROW_WRITE,   CFG_REFRACT_LEN, 19'd0,      '0},
    '{ROW_PREDICT, CFG_ALPHA_FAST,  19'd0,      '0},
    '{ROW_PREDICT, CFG_ALPHA_FAST,  19'd1000,   '0},
    '{ROW_PREDICT, CFG_ALPHA_FAST,  19'd2000,   '0},
    '{ROW_PREDICT, CFG_ALPHA_FAST,  19'd262143, '0},
    '{ROW_WRITE,   CFG_REFRACT_LEN, 19'd255,    '0},
    '{ROW_WRITE,   CFG_ALPHA_SLOW,  19'd65535,  '0},
    '{ROW_WRITE,   CFG_TROUGH_THR,  19'h40001,  '0},
    '{ROW_WRITE,   CFG_ALPHA_FAST,  19'd65535,  '0},
    '{ROW_WRITE,   CFG_WARMUP_LEN,  19'd3,      '0},
    '{ROW_PREDICT, CFG_ALPHA_FAST,  19'd0,      '0},
    '{ROW_PREDICT, CFG_ALPHA_FAST,  19'd262143, '0},
    '{ROW_PREDICT, CFG_ALPHA_FAST,  19'd0,      '0},
    '{ROW_PREDICT, CFG_ALPHA_FAST,  19'd5,      '0},
    '{ROW_PREDICT, CFG_ALPHA_FAST,  19'd262143, '0},
    '{ROW_PREDICT, CFG_ALPHA_FAST,  19'd1,      '0},
    '{ROW_PREDICT, CFG_ALPHA_FAST,  19'd174762, '0}
  };

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  // register copies, as written through the configuration channel
  logic [ALPHA_BITS-1:0]      cfg_alpha_fast = ALPHA_FAST_RST;
  logic [ALPHA_BITS-1:0]      cfg_alpha_slow = ALPHA_SLOW_RST;
  logic [WL_BITS-1:0]         cfg_warmup_len = WARMUP_LEN_RST;
  logic signed [THR_BITS-1:0] cfg_trough_thr = TROUGH_THR_RST;
  logic [REF_BITS-1:0]        cfg_refract    = REFRACT_RST;

  // tracker state
  longint unsigned dc_track     = 0;
  int unsigned     warm_count   = 0;
  longint          last_ac      = 0;
  int unsigned     lockout_left = 0;

  trough_res_t results_due[$];
  int unsigned mismatches  = 0;
  int unsigned cycle_count = 0;
  bit          calm        = 1'b0;

  ppg_beat_trough_detector u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Advance the DC tracker and beat test by one sample.
  function automatic trough_res_t track_sample(input logic [SAMPLE_BITS-1:0] raw);
    longint unsigned x;
    longint unsigned mag;
    longint unsigned alpha;
    int unsigned     len;
    int unsigned     cnt;
    bit              first;
    bit              warm;
    longint          ac;
    longint          thr;
    longint          ac_int;
    trough_res_t     res;
    x     = longint'(raw) << FRAC_BITS;
    len   = (cfg_warmup_len == 0) ? 1 : cfg_warmup_len;
    first = (warm_count == 0);
    cnt   = warm_count + 1;
    if (cnt > len) begin
      cnt = len;
    end
    warm_count = cnt;
    warm       = (cnt >= len);
    if (first) begin
      dc_track = x;
    end else begin
      alpha = warm ? cfg_alpha_slow : cfg_alpha_fast;
      if (x >= dc_track) begin
        mag      = (x - dc_track) * alpha;
        dc_track = dc_track + (mag >> 16);
      end else begin
        // round the step down, so the level falls by the ceiling
        mag      = (dc_track - x) * alpha;
        dc_track = dc_track - ((mag + 65535) >> 16);
      end
    end
    ac       = signed'(x) - signed'(dc_track);
    res.beat = 1'b0;
    if (warm) begin
      thr = longint'(cfg_trough_thr) * (longint'(1) << FRAC_BITS);
      if (lockout_left > 0) begin
        lockout_left = lockout_left - 1;
      end else if (last_ac < thr && ac > last_ac) begin
        res.beat     = 1'b1;
        lockout_left = cfg_refract;
      end
    end
    last_ac = ac;
    ac_int  = ac >>> FRAC_BITS;
    if (ac_int > longint'(AC_MAX)) begin
      ac_int = longint'(AC_MAX);
    end
    if (ac_int < longint'(AC_MIN)) begin
      ac_int = longint'(AC_MIN);
    end
    res.ac   = ac_int[AC_BITS-1:0];
    res.warm = warm;
    return res;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] raw, input bit typed,
                             input trough_res_t typed_res);
    trough_res_t predicted;
    while (!calm && $urandom_range(99) < GAP_PCT) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_TDATA_W'($urandom);
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_TDATA_W - SAMPLE_BITS){1'b0}}, raw};
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = track_sample(raw);
    results_due.push_back(typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  // Hold off requests until every expected result is out and the pipe is empty.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (results_due.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_W-1:0] value);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_ALPHA_FAST:  cfg_alpha_fast = value[ALPHA_BITS-1:0];
      CFG_ALPHA_SLOW:  cfg_alpha_slow = value[ALPHA_BITS-1:0];
      CFG_WARMUP_LEN:  cfg_warmup_len = value[WL_BITS-1:0];
      CFG_TROUGH_THR:  cfg_trough_thr = signed'(value[THR_BITS-1:0]);
      CFG_REFRACT_LEN: cfg_refract    = value[REF_BITS-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= GAP_PCT);
  end

  always @(posedge clk_i) begin : check_results
    trough_res_t want;
    trough_res_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.beat = m_axis_tdata[0];
      got.ac   = m_axis_tdata[AC_BITS:1];
      got.warm = m_axis_tdata[AC_BITS+1];
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("unexpected result: beat %0d ac %0d warm %0d",
                   got.beat, got.ac, got.warm);
        end
      end else begin
        want = results_due.pop_front();
        if (got.beat !== want.beat || got.ac !== want.ac || got.warm !== want.warm) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: beat %0d/%0d ac %0d/%0d warm %0d/%0d (expected/actual)",
                     want.beat, got.beat, want.ac, got.ac, want.warm, got.warm);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("ppg_beat_trough_detector regression: fail");
      $finish;
    end
  end

  initial begin
    int          base;
    int          amp;
    int          period;
    int          level;
    int          thr;
    int unsigned alpha_fast;
    int unsigned alpha_slow;
    int unsigned warmup_len;
    int unsigned refract_len;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[r]) begin
      case (dir_rows[r].kind)
        ROW_WRITE: begin
          write_reg(dir_rows[r].idx, dir_rows[r].value);
        end
        default: begin
          send_sample(dir_rows[r].value[SAMPLE_BITS-1:0], dir_rows[r].kind == ROW_TYPED,
                      dir_rows[r].typed);
        end
      endcase
    end

    for (int p = 0; p < 6; p++) begin
      base        = $urandom_range(20000, 240000);
      amp         = $urandom_range(200, 40000);
      period      = $urandom_range(6, 50);
      alpha_fast  = $urandom_range(200, 20000);
      alpha_slow  = $urandom_range(1, 3000);
      warmup_len  = $urandom_range(1, 40);
      thr         = -int'($urandom_range(0, amp / 2));
      refract_len = $urandom_range(0, 30);
      case (p)
        1: begin
          alpha_fast  = 65535;
          alpha_slow  = 1;
          thr         = -262143;
          refract_len = 255;
        end
        2: begin
          warmup_len = 1023;
        end
        3: begin
          thr         = 0;
          refract_len = 0;
          alpha_slow  = 65535;
        end
        4: begin
          warmup_len = 1;
          alpha_fast = 1;
          alpha_slow = 1;
        end
        default: ;
      endcase
      write_reg(CFG_ALPHA_FAST, CFG_DATA_W'(alpha_fast));
      write_reg(CFG_ALPHA_SLOW, CFG_DATA_W'(alpha_slow));
      write_reg(CFG_WARMUP_LEN, CFG_DATA_W'(warmup_len));
      write_reg(CFG_TROUGH_THR, CFG_DATA_W'(thr));
      write_reg(CFG_REFRACT_LEN, CFG_DATA_W'(refract_len));
      calm = (p == 2);
      for (int i = 0; i < 85; i++) begin
        if (p == 0 && i == 40) begin
          drain();
        end
        if ($urandom_range(99) < 10) begin
          level = $urandom_range(0, SAMPLE_MAX);
        end else begin
          // slow rise, then a sharp fall into the trough of the next beat
          level = base - amp / 2 + (amp * (i % period)) / period
                  + int'($urandom_range(0, amp / 16 + 1)) - amp / 32;
          if (level < 0) begin
            level = 0;
          end
          if (level > int'(SAMPLE_MAX)) begin
            level = SAMPLE_MAX;
          end
        end
        send_sample(SAMPLE_BITS'(level), 1'b0, '0);
      end
      calm = 1'b0;
    end

    drain();
    if (mismatches == 0 && results_due.size() == 0) begin
      $display("ppg_beat_trough_detector regression: pass");
    end else begin
      $display("ppg_beat_trough_detector regression: fail");
    end
    $finish;
  end

endmodule
